// ===== rtl/core/nmea_speed_satellite_extractor_top_macros.svh =====
// assertion macros for the nmea speed and satellite extractor
`ifndef NMEA_SPEED_SATELLITE_EXTRACTOR_TOP_MACROS_SVH
`define NMEA_SPEED_SATELLITE_EXTRACTOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define NSSE_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// condition in one cycle implies consequence in the next
`define NSSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define NSSE_ASSERT_ALWAYS(label, cond, msg)
`define NSSE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/nsse_pkg.sv =====
// constants for the nmea speed and satellite extractor
package nsse_pkg;

   localparam int MAX_LINE = 256;
   localparam int LEN_W    = $clog2(MAX_LINE + 1);

   localparam int BYTE_W   = 8;
   localparam int FIELD_W  = 5;
   localparam int SPEED_W  = 14;
   localparam int SATS_W   = 7;
   localparam int HIDX_W   = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [HIDX_W-1:0]  HDR_LEN    = 3'd6;
   localparam logic [SPEED_W-1:0] ACC_MAX    = 14'd9999;
   localparam logic [SATS_W-1:0]  SAT_MAX    = 7'd99;
   localparam logic [FIELD_W-1:0] FIELD_MAX  = 5'd31;
   localparam logic [FIELD_W-1:0] FIELD_RST  = 5'd7;

   localparam logic [BYTE_W-1:0] BYTE_ABORT = 8'h10;
   localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] BYTE_NINE  = 8'h39;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_FIELD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SATS_FIELD  = 2'd1;

   localparam logic KIND_GGA = 1'b0;
   localparam logic KIND_VTG = 1'b1;

   // expected header character "$GPGGA" at a position
   function automatic logic [BYTE_W-1:0] hdr_gga_char(input logic [HIDX_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      case (idx)
         3'd0: c = 8'h24;
         3'd1: c = 8'h47;
         3'd2: c = 8'h50;
         3'd3: c = 8'h47;
         3'd4: c = 8'h47;
         3'd5: c = 8'h41;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // expected header character "$GPVTG" at a position
   function automatic logic [BYTE_W-1:0] hdr_vtg_char(input logic [HIDX_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      case (idx)
         3'd0: c = 8'h24;
         3'd1: c = 8'h47;
         3'd2: c = 8'h50;
         3'd3: c = 8'h56;
         3'd4: c = 8'h54;
         3'd5: c = 8'h47;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/nmea_speed_satellite_extractor_top.sv =====
// top level of the nmea speed and satellite extractor
//
// usage
// - req channel: one received serial byte per word (req_rx_byte), taken when
//   req_valid is high and req_stall is low
// - rsp channel: one word per carriage return that ends a $GPGGA or $GPVTG
//   line, carrying both held values and the sentence kind (0 gga, 1 vtg)
// - csr port: index 0 writes the vtg speed field number, index 1 the gga
//   satellite field number; other indexes are ignored; write only when idle
// - path: a byte sits in the input register while the per-byte update runs,
//   and any result lands in the output register, which drives rsp_valid
// - throughput: one byte per cycle while rsp_stall holds no word in place
// - stall: while rsp_stall holds a word in the output register, the input
//   register keeps its byte and req_stall rises; once taken both move again
// - reset: synchronous, clears line state, held values, both registers'
//   valid flags and restores both field numbers to 7
// - byte 0x10 drops the current line; over-long lines end without a word
`include "nmea_speed_satellite_extractor_top_macros.svh"

module nmea_speed_satellite_extractor_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [nsse_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [nsse_pkg::SPEED_W-1:0]      rsp_speed_kmh,
   output logic [nsse_pkg::SATS_W-1:0]       rsp_satellites,
   output logic                              rsp_sentence_kind,
   input  logic                              csr_wr_en,
   input  logic [nsse_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nsse_pkg::FIELD_W-1:0]      csr_wdata
);
   import nsse_pkg::*;

   // configuration
   logic [FIELD_W-1:0] speed_field_ff, sats_field_ff;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff;

   // line state
   logic [HIDX_W-1:0]  header_index_ff, header_index_in;
   logic               match_gga_ff, match_gga_in;
   logic               match_vtg_ff, match_vtg_in;
   logic [FIELD_W-1:0] field_count_ff, field_count_in;
   logic [SPEED_W-1:0] digit_accum_ff, digit_accum_in;
   logic               fraction_seen_ff, fraction_seen_in;
   logic [LEN_W-1:0]   line_length_ff, line_length_in;
   logic [SPEED_W-1:0] speed_held_ff, speed_held_in;
   logic [SATS_W-1:0]  sats_held_ff, sats_held_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [SPEED_W-1:0] out_speed_ff;
   logic [SATS_W-1:0]  out_sats_ff;
   logic               out_kind_ff;

   logic               advance;
   logic               produce;
   logic               restart;
   logic               recognized;
   logic [FIELD_W-1:0] chosen;
   logic [SPEED_W+2:0] acc_next;

   // the byte in the input register moves on unless a finished word is stuck
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && produce) || (out_valid_ff && rsp_stall);

   assign recognized = (header_index_ff == HDR_LEN) && (match_gga_ff || match_vtg_ff);
   assign chosen     = match_vtg_ff ? speed_field_ff : sats_field_ff;
   // accum * 10 + digit, done as shift and add
   assign acc_next   = {digit_accum_ff, 3'b000} + {2'b00, digit_accum_ff, 1'b0}
                     + {{(SPEED_W-1){1'b0}}, in_byte_ff[3:0]};

   always_comb begin
      header_index_in  = header_index_ff;
      match_gga_in     = match_gga_ff;
      match_vtg_in     = match_vtg_ff;
      field_count_in   = field_count_ff;
      digit_accum_in   = digit_accum_ff;
      fraction_seen_in = fraction_seen_ff;
      line_length_in   = line_length_ff;
      speed_held_in    = speed_held_ff;
      sats_held_in     = sats_held_ff;
      produce          = 1'b0;
      restart          = 1'b0;

      if (advance) begin
         if (in_byte_ff == BYTE_ABORT) begin
            restart = 1'b1;
         end else if (in_byte_ff == BYTE_CR) begin
            if (recognized) begin
               produce = 1'b1;
               if (match_vtg_ff) begin
                  if (field_count_ff >= speed_field_ff) begin
                     speed_held_in = digit_accum_ff;
                  end
               end else if (field_count_ff >= sats_field_ff) begin
                  sats_held_in = (digit_accum_ff > SPEED_W'(SAT_MAX)) ?
                                 SAT_MAX : digit_accum_ff[SATS_W-1:0];
               end
            end
            restart = 1'b1;
         end else if (in_byte_ff == BYTE_LF && line_length_ff == '0) begin
            // leading line feed is dropped
         end else if (line_length_ff >= LEN_W'(MAX_LINE)) begin
            // over-long line can no longer be recognized
            match_gga_in = 1'b0;
            match_vtg_in = 1'b0;
         end else begin
            line_length_in = line_length_ff + LEN_W'(1);
            if (header_index_ff < HDR_LEN) begin
               if (in_byte_ff != hdr_gga_char(header_index_ff)) begin
                  match_gga_in = 1'b0;
               end
               if (in_byte_ff != hdr_vtg_char(header_index_ff)) begin
                  match_vtg_in = 1'b0;
               end
               header_index_in = header_index_ff + HIDX_W'(1);
            end else if (in_byte_ff == BYTE_COMMA) begin
               if (field_count_ff < FIELD_MAX) begin
                  field_count_in = field_count_ff + FIELD_W'(1);
               end else begin
                  fraction_seen_in = 1'b1;
               end
            end else if (recognized && field_count_ff == chosen && !fraction_seen_ff) begin
               if (in_byte_ff >= BYTE_ZERO && in_byte_ff <= BYTE_NINE) begin
                  digit_accum_in = (acc_next > (SPEED_W+3)'(ACC_MAX)) ?
                                   ACC_MAX : acc_next[SPEED_W-1:0];
               end else begin
                  // first non-digit freezes the value
                  fraction_seen_in = 1'b1;
               end
            end
         end
      end

      if (restart) begin
         header_index_in  = '0;
         match_gga_in     = 1'b1;
         match_vtg_in     = 1'b1;
         field_count_in   = '0;
         digit_accum_in   = '0;
         fraction_seen_in = 1'b0;
         line_length_in   = '0;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_field_ff <= FIELD_RST;
         sats_field_ff  <= FIELD_RST;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_SPEED_FIELD) begin
            speed_field_ff <= csr_wdata;
         end else if (csr_index == CSR_SATS_FIELD) begin
            sats_field_ff <= csr_wdata;
         end
      end
   end

   // control and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         header_index_ff  <= '0;
         match_gga_ff     <= 1'b1;
         match_vtg_ff     <= 1'b1;
         field_count_ff   <= '0;
         digit_accum_ff   <= '0;
         fraction_seen_ff <= 1'b0;
         line_length_ff   <= '0;
         speed_held_ff    <= '0;
         sats_held_ff     <= '0;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         header_index_ff  <= header_index_in;
         match_gga_ff     <= match_gga_in;
         match_vtg_ff     <= match_vtg_in;
         field_count_ff   <= field_count_in;
         digit_accum_ff   <= digit_accum_in;
         fraction_seen_ff <= fraction_seen_in;
         line_length_ff   <= line_length_in;
         speed_held_ff    <= speed_held_in;
         sats_held_ff     <= sats_held_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && produce) begin
         out_speed_ff <= speed_held_in;
         out_sats_ff  <= sats_held_in;
         out_kind_ff  <= match_vtg_ff ? KIND_VTG : KIND_GGA;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_speed_kmh     = out_speed_ff;
   assign rsp_satellites    = out_sats_ff;
   assign rsp_sentence_kind = out_kind_ff;

   // checks
   `NSSE_ASSERT_ALWAYS(a_stall_needs_byte, !req_stall || in_valid_ff,
      "input stalled with empty input register")
   `NSSE_ASSERT_NEXT(a_result_lands, advance && produce, rsp_valid,
      "finished word did not reach output register")
   `NSSE_ASSERT_ALWAYS(a_held_in_range,
      speed_held_ff <= ACC_MAX && sats_held_ff <= SAT_MAX,
      "held value above its saturation limit")
   `NSSE_ASSERT_ALWAYS(a_header_index_range, header_index_ff <= HDR_LEN,
      "header index ran past header length")

endmodule

// ===== test/nsse_sentence_checker.sv =====
`timescale 1ns / 100ps
// checker that predicts and compares the words of the nmea speed and satellite extractor
module nsse_sentence_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [nsse_pkg::BYTE_W-1:0]    req_rx_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [nsse_pkg::SPEED_W-1:0]   rsp_speed_kmh,
   input  logic [nsse_pkg::SATS_W-1:0]    rsp_satellites,
   input  logic                           rsp_sentence_kind,
   input  logic                           csr_wr_en,
   input  logic [nsse_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nsse_pkg::FIELD_W-1:0]   csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import nsse_pkg::*;

   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic [SATS_W-1:0]  sats;
      logic               kind;
   } sentence_word_type;

   localparam logic [47:0] GGA_TAG = "$GPGGA";
   localparam logic [47:0] VTG_TAG = "$GPVTG";

   logic [FIELD_W-1:0] vtg_speed_sel;
   logic [FIELD_W-1:0] gga_sats_sel;
   logic [HIDX_W-1:0]  hdr_pos;
   logic               gga_ok;
   logic               vtg_ok;
   logic [FIELD_W-1:0] field_no;
   logic [SPEED_W-1:0] accum;
   logic               frozen;
   logic [SPEED_W-1:0] speed_keep;
   logic [SATS_W-1:0]  sats_keep;
   logic [LEN_W-1:0]   line_len;
   sentence_word_type  words_due[$];

   task automatic restart_line();
      hdr_pos  = '0;
      gga_ok   = 1'b1;
      vtg_ok   = 1'b1;
      field_no = '0;
      accum    = '0;
      frozen   = 1'b0;
      line_len = '0;
   endtask

   // per-byte line parser; queues a word on cr after a known header
   task automatic parse_byte(input logic [BYTE_W-1:0] b);
      int unsigned        grown;
      logic [FIELD_W-1:0] target;
      sentence_word_type  w;
      if (b == BYTE_ABORT) begin
         restart_line();
      end else if (b == BYTE_CR) begin
         if (hdr_pos == HDR_LEN && (gga_ok || vtg_ok)) begin
            if (vtg_ok) begin
               if (field_no >= vtg_speed_sel) speed_keep = accum;
            end else if (field_no >= gga_sats_sel) begin
               sats_keep = (accum > SAT_MAX) ? SAT_MAX : accum[SATS_W-1:0];
            end
            w.speed = speed_keep;
            w.sats  = sats_keep;
            w.kind  = vtg_ok ? KIND_VTG : KIND_GGA;
            words_due.push_back(w);
         end
         restart_line();
      end else if (b == BYTE_LF && line_len == 0) begin
         // leading line feed is dropped
      end else if (line_len >= MAX_LINE) begin
         gga_ok = 1'b0;
         vtg_ok = 1'b0;
      end else begin
         line_len = line_len + 1'b1;
         if (hdr_pos < HDR_LEN) begin
            if (b != GGA_TAG[47 - 8*hdr_pos -: 8]) gga_ok = 1'b0;
            if (b != VTG_TAG[47 - 8*hdr_pos -: 8]) vtg_ok = 1'b0;
            hdr_pos = hdr_pos + 1'b1;
         end else if (b == BYTE_COMMA) begin
            if (field_no < FIELD_MAX) field_no = field_no + 1'b1;
            else frozen = 1'b1;
         end else if (gga_ok || vtg_ok) begin
            target = vtg_ok ? vtg_speed_sel : gga_sats_sel;
            if (field_no == target && !frozen) begin
               if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
                  grown = accum * 10 + (b - BYTE_ZERO);
                  accum = (grown > ACC_MAX) ? ACC_MAX : grown[SPEED_W-1:0];
               end else begin
                  frozen = 1'b1;
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      sentence_word_type want;
      if (reset) begin
         vtg_speed_sel = FIELD_RST;
         gga_sats_sel  = FIELD_RST;
         speed_keep    = '0;
         sats_keep     = '0;
         restart_line();
         words_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SPEED_FIELD: vtg_speed_sel = csr_wdata;
               CSR_SATS_FIELD:  gga_sats_sel  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) parse_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (words_due.size() == 0) begin
               fail_count++;
               $display("%0t unexpected word: expected none, actual speed %0d sats %0d kind %0d",
                        $time, rsp_speed_kmh, rsp_satellites, rsp_sentence_kind);
            end else begin
               want = words_due.pop_front();
               if (rsp_speed_kmh !== want.speed) begin
                  fail_count++;
                  $display("%0t speed_kmh mismatch: expected %0d actual %0d",
                           $time, want.speed, rsp_speed_kmh);
               end
               if (rsp_satellites !== want.sats) begin
                  fail_count++;
                  $display("%0t satellites mismatch: expected %0d actual %0d",
                           $time, want.sats, rsp_satellites);
               end
               if (rsp_sentence_kind !== want.kind) begin
                  fail_count++;
                  $display("%0t sentence_kind mismatch: expected %0d actual %0d",
                           $time, want.kind, rsp_sentence_kind);
               end
            end
         end
      end
      pending <= words_due.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for the nmea speed and satellite extractor
module tb;
   import nsse_pkg::*;

   localparam int CYCLE_LIMIT  = 150000;
   localparam int PHASE_BYTES  = 100;
   localparam int HOLD_CYCLES  = 250;
   localparam int SETTLE_CYCLES = 6;
   // indexes the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam logic [BYTE_W-1:0]    BYTE_FILL   = 8'h78;   // 'x'

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_rx_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [SPEED_W-1:0]   rsp_speed_kmh;
   logic [SATS_W-1:0]    rsp_satellites;
   logic                 rsp_sentence_kind;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FIELD_W-1:0]   csr_wdata;

   int          fail_count;
   int          pending;
   int          tx_gap_pct;
   int          rx_stall_pct;
   int unsigned bytes_sent;
   int unsigned cycles;
   logic        hold_go;
   logic        rsp_hold;
   logic [FIELD_W-1:0] cfg_speed;
   logic [FIELD_W-1:0] cfg_sats;

   nmea_speed_satellite_extractor_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_speed_kmh     (rsp_speed_kmh),
      .rsp_satellites    (rsp_satellites),
      .rsp_sentence_kind (rsp_sentence_kind),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   nsse_sentence_checker u_watch (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_speed_kmh     (rsp_speed_kmh),
      .rsp_satellites    (rsp_satellites),
      .rsp_sentence_kind (rsp_sentence_kind),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a run that hangs or loses a word ends here
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb failed");
      $finish;
   end

   // long receiver hold-off, counted in its own process; flips on rising edges
   // so the receiver below picks it up cleanly at the falling edge
   initial begin
      rsp_hold = 1'b0;
      wait (hold_go);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // receiver: random stall at each falling edge, forced high during the hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= rsp_hold || ($urandom_range(99) < rx_stall_pct);
      end
   end

   // offer one byte, with random idle cycles ahead of it, and wait for the take;
   // called and returns at a falling edge
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_byte(BYTE_CR);
   endtask

   task automatic send_commas(input int n);
      repeat (n) send_byte(BYTE_COMMA);
   endtask

   task automatic send_digits(input int n);
      repeat (n) send_byte(BYTE_W'(BYTE_ZERO + $urandom_range(9)));
   endtask

   // prefix, then fill bytes up to a total line length, no terminator
   task automatic send_padded(input string s, input int total);
      send_text(s);
      repeat (total - s.len()) send_byte(BYTE_FILL);
   endtask

   // drop valid, let every word drain, then let the pipeline empty out
   task automatic settle();
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_field(input logic [CSR_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_fields(input logic [FIELD_W-1:0] spd, input logic [FIELD_W-1:0] sat);
      settle();
      write_field(CSR_SPEED_FIELD, spd);
      write_field(CSR_SATS_FIELD, sat);
      cfg_speed = spd;
      cfg_sats  = sat;
   endtask

   // mostly small field numbers, now and then the extremes 0 and 31
   function automatic logic [FIELD_W-1:0] pick_field();
      if ($urandom_range(7) == 0) return $urandom_range(1) ? FIELD_MAX : '0;
      return FIELD_W'($urandom_range(1, 8));
   endfunction

   // one random line: mostly well-formed gga or vtg with random field content,
   // some with a broken header, some pure noise, a few aborted or noisy
   task automatic send_random_line();
      int    shape;
      int    sel;
      int    nfields;
      int    mode;
      int    pos;
      string tag;
      string junk;
      junk  = "0123456789.NEKM-,";
      shape = $urandom_range(19);
      if (shape == 0) begin
         repeat ($urandom_range(1, 30)) send_byte(BYTE_W'($urandom_range(255)));
         send_byte(BYTE_CR);
         return;
      end
      if (shape < 10) begin
         send_text("$GPGGA");
         sel = cfg_sats;
      end else if (shape < 18) begin
         send_text("$GPVTG");
         sel = cfg_speed;
      end else begin
         // header with one byte replaced
         tag = $urandom_range(1) ? "$GPGGA" : "$GPVTG";
         pos = $urandom_range(5);
         for (int i = 0; i < 6; i++)
            send_byte((i == pos) ? BYTE_W'($urandom_range(255)) : tag[i]);
         sel = $urandom_range(1) ? cfg_sats : cfg_speed;
      end
      // sometimes the line stops before the chosen field
      nfields = sel + $urandom_range(3) - (($urandom_range(4) == 0) ? 2 : 0);
      if (nfields < 0) nfields = 0;
      for (int i = 0; i <= nfields; i++) begin
         if (i > 0) send_byte(BYTE_COMMA);
         if ($urandom_range(70) == 0) send_byte(BYTE_ABORT);
         if ($urandom_range(50) == 0) send_byte(BYTE_W'($urandom_range(255)));
         if (i == sel) begin
            mode = $urandom_range(5);
            case (mode)
               0: ;                                    // empty field
               1: send_digits($urandom_range(1, 3));
               2: begin
                  send_digits($urandom_range(1, 4));
                  send_byte(".");
                  send_digits($urandom_range(1, 2));
               end
               3: begin
                  send_byte("-");
                  send_digits($urandom_range(1, 2));
               end
               4: send_digits($urandom_range(4, 7));   // saturation
               default: begin
                  send_digits($urandom_range(1, 3));
                  send_byte("K");
               end
            endcase
         end else if (i > 0 && $urandom_range(2) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(junk[$urandom_range(junk.len() - 1)]);
         end
      end
      send_byte(BYTE_CR);
      if ($urandom_range(3) != 0) send_byte(BYTE_LF);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = '0;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      tx_gap_pct   = 35;
      rx_stall_pct = 69;
      hold_go      = 1'b0;
      bytes_sent   = 0;
      cfg_speed    = FIELD_RST;
      cfg_sats     = FIELD_RST;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset field numbers
      send_byte(BYTE_LF);                       // leading line feed, dropped
      send_line("$GPVTG,,,,,,,123.45,K");       // fraction cut off
      send_byte(BYTE_LF);
      send_line("$GPGGA,,,,,,,150,x");          // count clamped to 99
      send_line("$GPVTG,,,,,,,99999");          // accumulator saturates
      send_line("$GPVTG,1,2");                  // line ends before the field, value kept
      send_line("$GPVTG,,,,,,,");               // field present but empty
      send_line("$GPGGA,,,,,,,-5");             // sign freezes the value
      send_line("$GPGGA,,,,,,,08");
      send_line("$GPGG");                       // too short for a header
      send_line("$GPXYZ,,,,,,,5");              // unknown header
      send_text("$GPVTG,,,,,,,3");
      send_byte(BYTE_ABORT);                    // abandon the line
      send_line(",4");
      send_padded("$GPVTG,,,,,,,8", MAX_LINE);  // exactly at the length limit
      send_byte(BYTE_CR);
      send_padded("$GPVTG,,,,,,,6", MAX_LINE + 1);
      send_byte(BYTE_CR);                       // over-long, no word
      send_padded("$GPGGA,,,,,,,6", MAX_LINE + 4);
      send_byte(BYTE_ABORT);

      // field zero: bytes right after the header
      set_fields('0, '0);
      send_line("$GPVTG42,1");
      send_line("$GPGGA7");

      // top field number, and the comma count saturating past it
      set_fields(FIELD_MAX, FIELD_MAX);
      send_text("$GPGGA");
      send_commas(31);
      send_line("55,66");
      send_text("$GPVTG");
      send_commas(31);
      send_line("1234,5");
      send_text("$GPGGA");
      send_commas(33);
      send_line("9");

      // writes to unused indexes must leave both field numbers alone
      settle();
      write_field(CSR_SPARE_2, 5'd3);
      write_field(CSR_SPARE_3, 5'd5);
      send_text("$GPVTG");
      send_commas(31);
      send_line("77");

      // random part in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         set_fields(pick_field(), pick_field());
         case (phase)
            0: begin
               tx_gap_pct   = 35;
               rx_stall_pct = 69;
            end
            1: begin
               tx_gap_pct   = 69;
               rx_stall_pct = 35;
            end
            default: begin
               tx_gap_pct   = 0;
               rx_stall_pct = 0;
               // sender keeps going while the receiver holds off
               hold_go      = 1'b1;
            end
         endcase
         for (int unsigned stop = bytes_sent + PHASE_BYTES; bytes_sent < stop; )
            send_random_line();
      end

      // drain and let any stray word show up
      settle();
      repeat (20) @(negedge clock);
      if (fail_count == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

endmodule
